>>> hdl/nes_pkg.sv
// Shared types and constants for the note event sequencer.
package nes_pkg;

  typedef enum logic [2:0] {
    OP_LOAD_EVENT = 3'd0,
    OP_LOAD_TRACK = 3'd1,
    OP_START      = 3'd2,
    OP_TICK       = 3'd3,
    OP_STOP       = 3'd4
  } nes_op_e;

  typedef enum logic {
    CFG_SECTION_LENGTH = 1'b0,
    CFG_ACTIVE_TRACKS  = 1'b1
  } nes_cfg_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [9:0]  event_index;
    logic [6:0]  event_note;
    logic [15:0] event_frames;
    logic [2:0]  track_slot;
    logic [3:0]  track_channel;
    logic [7:0]  track_level;
    logic [9:0]  track_first;
    logic [10:0] track_length;
  } nes_in_t;

  typedef struct packed {
    logic       write_target;
    logic [3:0] write_channel;
    logic [4:0] write_offset;
    logic [7:0] write_data;
    logic       last;
  } nes_out_t;

  typedef struct packed {
    nes_op_e kind;
    nes_in_t item;
  } nes_cmd_t;

  localparam logic       TGT_CHANNEL   = 1'b0;
  localparam logic       TGT_KEYON     = 1'b1;
  localparam logic [3:0] NOISE_CH      = 4'd11;
  localparam logic [3:0] PSG_CH_FIRST  = 4'd8;
  localparam logic [4:0] OFF_PERIOD_HI = 5'h00;
  localparam logic [4:0] OFF_PERIOD_LO = 5'h01;
  localparam logic [4:0] OFF_ATTEN     = 5'h02;
  localparam logic [4:0] OFF_CTRL      = 5'h00;
  localparam logic [4:0] OFF_BLOCK     = 5'h1C;
  localparam logic [4:0] OFF_FNUM      = 5'h1D;
  localparam logic [3:0] KEYON_ALL     = 4'hF;
  localparam logic [7:0] CTRL_SNARE    = 8'h05;
  localparam logic [7:0] CTRL_HAT      = 8'h04;
  localparam logic [7:0] CTRL_KICK     = 8'h02;
  localparam logic [3:0] ATTEN_MAX     = 4'd15;
  localparam logic [4:0] PSG_ATT_BASE  = 5'd6;
  localparam logic [4:0] PERC_ATT_BASE = 5'd3;
  localparam logic [4:0] MAX_WRITES    = 5'd24;
  localparam logic [6:0] NOTE_REST     = 7'd0;
  localparam logic [6:0] NOTE_HOLD     = 7'd1;
  localparam logic [6:0] NOTE_BASE     = 7'd2;
  localparam logic [6:0] NOTE_SNARE    = 7'd3;
  localparam logic [6:0] NOTE_HAT      = 7'd4;
  localparam logic [6:0] NOTE_TOP      = 7'd97;

endpackage

>>> hdl/nes_front.sv
// Front end: accept items, drop unknown ops, queue classified commands.
module nes_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  nes_pkg::nes_in_t in_data_i,
  output logic             cmd_valid_o,
  output nes_pkg::nes_cmd_t cmd_o,
  input  logic             cmd_take_i
);
  import nes_pkg::*;

  nes_cmd_t   slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       known;
  nes_op_e    kind;
  logic       wr, rd;

  always_comb begin
    known = 1'b1;
    kind  = OP_TICK;
    case (in_data_i.op)
      OP_LOAD_EVENT: kind = OP_LOAD_EVENT;
      OP_LOAD_TRACK: kind = OP_LOAD_TRACK;
      OP_START:      kind = OP_START;
      OP_TICK:       kind = OP_TICK;
      OP_STOP:       kind = OP_STOP;
      default:       known = 1'b0;
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rp_q];
  assign wr          = push && !full && known;
  assign rd          = cmd_take_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      slot_q[wp_q] <= '{kind: kind, item: in_data_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

>>> hdl/nes_back.sv
// Back end: event store, track table, cursors and the register-write sequencer.
module nes_back #(
  parameter int EVENT_DEPTH = 1024,
  parameter int TRACK_SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [23:0]       cfg_data_i,
  input  logic              cmd_valid_i,
  input  nes_pkg::nes_cmd_t cmd_i,
  output logic              cmd_take_o,
  output logic              out_push_o,
  output nes_pkg::nes_out_t out_data_o,
  input  logic              out_full_i
);
  import nes_pkg::*;

  localparam int AW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int SW = (AW + 1 > 12) ? AW + 1 : 12;
  localparam int IW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int CW = $clog2(TRACK_SLOTS + 1);

  typedef struct packed {
    logic [1:0]   n;
    nes_out_t [2:0] w;
  } gen_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SIL, S_TCHK, S_TMOD, S_TRD, S_TGEN, S_EMIT, S_FIN
  } state_e;

  function automatic logic [10:0] fnum_f(input logic [3:0] pc);
    logic [10:0] r;
    case (pc)
      4'd0:    r = 11'd644;
      4'd1:    r = 11'd682;
      4'd2:    r = 11'd723;
      4'd3:    r = 11'd766;
      4'd4:    r = 11'd811;
      4'd5:    r = 11'd859;
      4'd6:    r = 11'd910;
      4'd7:    r = 11'd965;
      4'd8:    r = 11'd1022;
      4'd9:    r = 11'd1083;
      4'd10:   r = 11'd1147;
      default: r = 11'd1215;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] period_f(input logic [3:0] pc);
    logic [8:0] r;
    case (pc)
      4'd0:    r = 9'd428;
      4'd1:    r = 9'd404;
      4'd2:    r = 9'd381;
      4'd3:    r = 9'd360;
      4'd4:    r = 9'd339;
      4'd5:    r = 9'd320;
      4'd6:    r = 9'd302;
      4'd7:    r = 9'd285;
      4'd8:    r = 9'd269;
      4'd9:    r = 9'd254;
      4'd10:   r = 9'd240;
      default: r = 9'd226;
    endcase
    return r;
  endfunction

  function automatic nes_out_t mk(input logic t, input logic [3:0] ch,
                                 input logic [4:0] off, input logic [7:0] d);
    nes_out_t o;
    o.write_target  = t;
    o.write_channel = ch;
    o.write_offset  = off;
    o.write_data    = d;
    o.last          = 1'b0;
    return o;
  endfunction

  // Translate one note on one channel into up to three register writes.
  function automatic gen_t gen(input logic [3:0] ch, input logic [7:0] lvl,
                               input logic [6:0] note);
    gen_t        g;
    logic [3:0]  steps;
    logic [6:0]  nc, absn;
    logic [12:0] prod;
    logic [2:0]  oct;
    logic [3:0]  pc;
    logic [10:0] fn;
    logic [15:0] per;
    logic [4:0]  pa, at;
    logic [7:0]  ctrl;
    g     = '0;
    steps = (lvl == 8'd0 || lvl > 8'd15) ? 4'd0 : 4'(8'd15 - lvl);
    nc    = (note > NOTE_TOP) ? NOTE_TOP : note;
    absn  = nc - NOTE_BASE;
    prod  = 13'(absn) * 13'd43;
    oct   = prod[11:9];
    pc    = 4'(absn - 7'(oct) * 7'd12);
    fn    = fnum_f(pc);
    per   = 16'(period_f(pc));
    per   = (oct < 3'd4) ? (per << (3'd4 - oct)) : (per >> (oct - 3'd4));
    pa    = PERC_ATT_BASE + 5'(steps);
    at    = PSG_ATT_BASE + 5'(steps);
    ctrl  = (note == NOTE_SNARE) ? CTRL_SNARE : ((note == NOTE_HAT) ? CTRL_HAT : CTRL_KICK);
    if (ch > NOISE_CH) begin
      g.n = 2'd0;
    end else if (note == NOTE_REST || (note == NOTE_HOLD && ch != NOISE_CH)) begin
      g.n = 2'd1;
      if (ch < PSG_CH_FIRST) g.w[0] = mk(TGT_KEYON, ch, 5'd0, {4'd0, ch});
      else                   g.w[0] = mk(TGT_CHANNEL, ch, OFF_ATTEN, {4'd0, ATTEN_MAX});
    end else if (ch == NOISE_CH) begin
      g.n    = 2'd2;
      g.w[0] = mk(TGT_CHANNEL, ch, OFF_CTRL, ctrl);
      g.w[1] = mk(TGT_CHANNEL, ch, OFF_ATTEN,
                  {4'd0, (pa > 5'd15) ? ATTEN_MAX : pa[3:0]});
    end else if (ch < PSG_CH_FIRST) begin
      g.n    = 2'd3;
      g.w[0] = mk(TGT_CHANNEL, ch, OFF_BLOCK, {2'b00, oct, fn[10:8]});
      g.w[1] = mk(TGT_CHANNEL, ch, OFF_FNUM, fn[7:0]);
      g.w[2] = mk(TGT_KEYON, ch, 5'd0, {KEYON_ALL, ch});
    end else begin
      g.n    = 2'd3;
      g.w[0] = mk(TGT_CHANNEL, ch, OFF_PERIOD_HI, per[15:8]);
      g.w[1] = mk(TGT_CHANNEL, ch, OFF_PERIOD_LO, per[7:0]);
      g.w[2] = mk(TGT_CHANNEL, ch, OFF_ATTEN,
                  {4'd0, (at > 5'd15) ? ATTEN_MAX : at[3:0]});
    end
    return g;
  endfunction

  // Storage
  logic [22:0] mem [EVENT_DEPTH];
  logic [22:0] rdata_q;
  logic [3:0]  tch_q  [TRACK_SLOTS];
  logic [7:0]  tlvl_q [TRACK_SLOTS];
  logic [9:0]  tfst_q [TRACK_SLOTS];
  logic [10:0] tlen_q [TRACK_SLOTS];
  logic [10:0] pos_q  [TRACK_SLOTS];
  logic [15:0] fl_q   [TRACK_SLOTS];

  logic [23:0] seclen_q, sec_q;
  logic [3:0]  active_q;
  logic        playing_q;
  logic [3:0]  shadow_q;

  state_e      state_q, ret_q;
  nes_op_e     kind_q;
  logic [CW-1:0] i_q;
  logic [SW-1:0] sum_q;
  gen_t        g_q;
  logic [1:0]  k_q;
  logic [4:0]  cnt_q;
  nes_out_t    pend_q;
  logic        pend_v_q;

  logic [CW-1:0] n_trk;
  logic [IW-1:0] ix;
  logic          ev_we, trk_we;
  nes_out_t      w_cur;
  logic          emit_go, fin_go;
  gen_t          g_sil, g_ev, g_dec;
  logic [4:0]    decay;

  assign n_trk = (active_q > 4'(TRACK_SLOTS)) ? CW'(TRACK_SLOTS) : CW'(active_q);
  assign ix    = i_q[IW-1:0];
  assign w_cur = g_q.w[k_q];
  assign g_sil = gen(tch_q[ix], tlvl_q[ix], NOTE_REST);
  assign g_ev  = gen(tch_q[ix], tlvl_q[ix], rdata_q[22:16]);
  assign decay = 5'(shadow_q) + 5'd2;

  // Percussion decay: one attenuation write, saturated at silence.
  always_comb begin
    g_dec      = '0;
    g_dec.n    = 2'd1;
    g_dec.w[0] = mk(TGT_CHANNEL, NOISE_CH, OFF_ATTEN,
                    {4'd0, (decay > 5'd15) ? ATTEN_MAX : decay[3:0]});
  end

  assign ev_we  = (state_q == S_IDLE) && cmd_valid_i && cmd_i.kind == OP_LOAD_EVENT &&
                  (32'(cmd_i.item.event_index) < EVENT_DEPTH);
  assign trk_we = (state_q == S_IDLE) && cmd_valid_i && cmd_i.kind == OP_LOAD_TRACK &&
                  (32'(cmd_i.item.track_slot) < TRACK_SLOTS);

  assign emit_go = (state_q == S_EMIT) && (k_q < g_q.n) && !(pend_v_q && out_full_i);
  assign fin_go  = (state_q == S_FIN) && (!pend_v_q || !out_full_i);

  always_comb begin
    out_push_o = 1'b0;
    out_data_o = pend_q;
    cmd_take_o = 1'b0;
    if (emit_go && cnt_q < MAX_WRITES && pend_v_q) out_push_o = 1'b1;
    if (fin_go && pend_v_q) begin
      out_push_o      = 1'b1;
      out_data_o.last = 1'b1;
    end
    if (state_q == S_IDLE && cmd_valid_i) begin
      case (cmd_i.kind)
        OP_START: cmd_take_o = !playing_q;
        OP_TICK, OP_STOP: cmd_take_o = !playing_q;
        default: cmd_take_o = 1'b1;
      endcase
    end
    if (fin_go) cmd_take_o = 1'b1;
  end

  // Event store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ev_we) begin
      mem[AW'(cmd_i.item.event_index)] <= {cmd_i.item.event_note, cmd_i.item.event_frames};
    end
    rdata_q <= mem[sum_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (trk_we) begin
      tch_q[IW'(cmd_i.item.track_slot)]  <= cmd_i.item.track_channel;
      tlvl_q[IW'(cmd_i.item.track_slot)] <= cmd_i.item.track_level;
      tfst_q[IW'(cmd_i.item.track_slot)] <= cmd_i.item.track_first;
      tlen_q[IW'(cmd_i.item.track_slot)] <= cmd_i.item.track_length;
    end
    if (state_q == S_TCHK && i_q != n_trk && fl_q[ix] == 16'd0 && pos_q[ix] < tlen_q[ix]) begin
      sum_q <= SW'(tfst_q[ix]) + SW'(pos_q[ix]);
    end else if (state_q == S_TMOD && 32'(sum_q) >= EVENT_DEPTH) begin
      sum_q <= sum_q - SW'(EVENT_DEPTH);
    end
    if (state_q == S_SIL && i_q != n_trk) g_q <= g_sil;
    else if (state_q == S_TGEN) g_q <= g_ev;
    else if (state_q == S_TCHK && i_q != n_trk) g_q <= g_dec;
    if (emit_go && cnt_q < MAX_WRITES) pend_q <= w_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      kind_q    <= OP_TICK;
      i_q       <= '0;
      k_q       <= 2'd0;
      cnt_q     <= 5'd0;
      pend_v_q  <= 1'b0;
      seclen_q  <= 24'd0;
      active_q  <= 4'd0;
      sec_q     <= 24'd0;
      playing_q <= 1'b0;
      shadow_q  <= ATTEN_MAX;
      for (int t = 0; t < TRACK_SLOTS; t++) begin
        pos_q[t] <= 11'd0;
        fl_q[t]  <= 16'd0;
      end
    end else begin
      if (cfg_we_i) begin
        case (nes_cfg_e'(cfg_index_i))
          CFG_SECTION_LENGTH: seclen_q <= cfg_data_i;
          CFG_ACTIVE_TRACKS:  active_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (emit_go) begin
        k_q <= k_q + 2'd1;
        if (w_cur.write_target == TGT_CHANNEL && w_cur.write_channel == NOISE_CH &&
            w_cur.write_offset == OFF_ATTEN) begin
          shadow_q <= w_cur.write_data[3:0];
        end
        if (cnt_q < MAX_WRITES) begin
          pend_v_q <= 1'b1;
          cnt_q    <= cnt_q + 5'd1;
        end
      end
      case (state_q)
        S_IDLE: begin
          i_q <= '0;
          if (cmd_valid_i) begin
            kind_q <= cmd_i.kind;
            case (cmd_i.kind)
              OP_START: begin
                if (playing_q) state_q <= S_SIL;
                else begin
                  playing_q <= 1'b1;
                  sec_q     <= seclen_q;
                  for (int t = 0; t < TRACK_SLOTS; t++) begin
                    pos_q[t] <= 11'd0;
                    fl_q[t]  <= 16'd0;
                  end
                end
              end
              OP_TICK: if (playing_q) state_q <= S_TCHK;
              OP_STOP: if (playing_q) state_q <= S_SIL;
              default: ;
            endcase
          end
        end
        S_SIL: begin
          if (i_q == n_trk) state_q <= S_FIN;
          else begin
            i_q     <= i_q + CW'(1);
            k_q     <= 2'd0;
            ret_q   <= S_SIL;
            state_q <= S_EMIT;
          end
        end
        S_TCHK: begin
          if (i_q == n_trk) begin
            // Advance the section counter; rewind when it runs out.
            if (sec_q <= 24'd1) begin
              sec_q <= seclen_q;
              for (int t = 0; t < TRACK_SLOTS; t++) begin
                pos_q[t] <= 11'd0;
                fl_q[t]  <= 16'd0;
              end
            end else begin
              sec_q <= sec_q - 24'd1;
            end
            state_q <= S_FIN;
          end else if (fl_q[ix] == 16'd0 && pos_q[ix] < tlen_q[ix]) begin
            state_q <= S_TMOD;
          end else begin
            if (fl_q[ix] != 16'd0) fl_q[ix] <= fl_q[ix] - 16'd1;
            i_q <= i_q + CW'(1);
            if (tch_q[ix] == NOISE_CH && shadow_q < ATTEN_MAX) begin
              k_q     <= 2'd0;
              ret_q   <= S_TCHK;
              state_q <= S_EMIT;
            end
          end
        end
        S_TMOD: begin
          if (32'(sum_q) < EVENT_DEPTH) state_q <= S_TRD;
        end
        S_TRD: state_q <= S_TGEN;
        S_TGEN: begin
          fl_q[ix]  <= (rdata_q[15:0] == 16'd0) ? 16'd0 : rdata_q[15:0] - 16'd1;
          pos_q[ix] <= pos_q[ix] + 11'd1;
          i_q       <= i_q + CW'(1);
          k_q       <= 2'd0;
          ret_q     <= S_TCHK;
          state_q   <= S_EMIT;
        end
        S_EMIT: begin
          if (k_q >= g_q.n) state_q <= ret_q;
        end
        S_FIN: begin
          if (fin_go) begin
            pend_v_q <= 1'b0;
            cnt_q    <= 5'd0;
            state_q  <= S_IDLE;
            if (kind_q == OP_START) begin
              playing_q <= 1'b1;
              sec_q     <= seclen_q;
              for (int t = 0; t < TRACK_SLOTS; t++) begin
                pos_q[t] <= 11'd0;
                fl_q[t]  <= 16'd0;
              end
            end else if (kind_q == OP_STOP) begin
              playing_q <= 1'b0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/nes_out_fifo.sv
// Result queue between the sequencer and the output port.
module nes_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  nes_pkg::nes_out_t data_i,
  output logic              full_o,
  input  logic              pop,
  output logic              empty,
  output nes_pkg::nes_out_t data_o
);
  import nes_pkg::*;

  nes_out_t   buf_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       wr, rd;

  assign full_o = (cnt_q == 3'd4);
  assign empty  = (cnt_q == 3'd0);
  assign data_o = buf_q[rp_q];
  assign wr     = push_i && !full_o;
  assign rd     = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (wr) buf_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 2'd0;
      rp_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      if (wr) wp_q <= wp_q + 2'd1;
      if (rd) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'b00, wr} - {2'b00, rd};
    end
  end

endmodule

>>> hdl/note_event_sequencer_unit.sv
// Top level of the note event sequencer: front end, back end and result queue.
//
// Items go in through a queue-style push/full port and register-write results
// come out through an empty/pop port; a two-entry command queue separates the
// front end (accept, drop unknown ops) from the back end (execute), and a
// four-entry result queue holds writes until they are popped. Load items
// cause no transaction. A tick walks the played tracks one at a time: a
// track that fetches nothing emits at most a percussion decay, and a track
// that fetches an event wraps first+position back below EVENT_DEPTH, reads
// the store, generates its writes and emits them. A start or stop while
// playing silences each played track in turn (no write for a channel without
// registers). A tick, or a start or stop while playing, ends in a final state
// that flags its final write with last. Whenever the result queue is full the
// back end holds its writes. The event store and the track table are not
// cleared at reset; load entries before playing them.
module note_event_sequencer_unit #(
  parameter int EVENT_DEPTH = 1024,
  parameter int TRACK_SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  nes_pkg::nes_in_t  in_data_i,
  output logic              empty,
  input  logic              pop,
  output nes_pkg::nes_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [23:0]       cfg_data_i
);
  import nes_pkg::*;

  logic     cmd_valid, cmd_take;
  nes_cmd_t cmd;
  logic     res_push, res_full;
  nes_out_t res_data;

  // Accept and classify items.
  nes_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  // Execute commands and produce register writes.
  nes_back #(
    .EVENT_DEPTH (EVENT_DEPTH),
    .TRACK_SLOTS (TRACK_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .out_push_o  (res_push),
    .out_data_o  (res_data),
    .out_full_i  (res_full)
  );

  // Hold results until popped.
  nes_out_fifo u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_data),
    .full_o (res_full),
    .pop    (pop),
    .empty  (empty),
    .data_o (out_data_o)
  );

endmodule
